[hw/rtl/met_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the Mandelbrot escape-time unit.
// No dependencies; used by the controller, datapath and top level.
package met_pkg;

    // Fixed-point format and image limits
    localparam int FRAC_BITS      = 26;
    localparam int MAX_IMAGE_SIZE = 4096;

    // Field and register widths
    localparam int PIX_W      = 12;
    localparam int LIMIT_W    = 16;
    localparam int RADIUS_W   = 31;
    localparam int STEP_W     = 31;
    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  RST_ITER_LIMIT = 16'd256;
    localparam logic [RADIUS_W-1:0] RST_RADIUS_SQ  = 31'd268435456;
    localparam logic [STEP_W-1:0]   RST_STEP_SIZE  = 31'd262144;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_SIZE = 13'd1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ITER_LIMIT = 3'd0,
        REG_RADIUS_SQ  = 3'd1,
        REG_STEP_SIZE  = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_IMAGE_SIZE = 3'd5
    } t_reg_idx;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_px;   // capture pixel coordinates
        logic map_mul;   // relative coordinate times step
        logic c_load;    // add offsets, set c and z
        logic sq_mul;    // re*re, im*im, re*im
        logic new_calc;  // form new re, im
        logic mag_mul;   // squares of new re, im
        logic z_upd;     // z = z' + c
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic escaped;
    } t_dp_status;

    // Clamp a 64-bit signed value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic all_same;
        all_same = (v[PROD_W-1:COORD_W-1] == '0) || (v[PROD_W-1:COORD_W-1] == '1);
        if (all_same) begin
            sat32 = v[COORD_W-1:0];
        end else if (v[PROD_W-1]) begin
            sat32 = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

[hw/rtl/met_dp.sv]
`timescale 1ns / 1ps
// Datapath of the escape-time unit: coordinate mapping, squaring rounds, escape test.
// Depends on met_pkg; driven by met_ctrl through t_dp_cmd.
module met_dp (
    input  logic                                i_clk,
    input  met_pkg::t_dp_cmd                    i_cmd,
    input  logic [met_pkg::PIX_W-1:0]           i_pixel_column,
    input  logic [met_pkg::PIX_W-1:0]           i_pixel_row,
    input  logic [met_pkg::RADIUS_W-1:0]        i_radius_sq,
    input  logic [met_pkg::STEP_W-1:0]          i_step_size,
    input  logic signed [met_pkg::COORD_W-1:0]  i_offset_x,
    input  logic signed [met_pkg::COORD_W-1:0]  i_offset_y,
    input  logic [met_pkg::SIZE_W-1:0]          i_image_size,
    output met_pkg::t_dp_status                 o_status
);

    logic [met_pkg::PIX_W-1:0]          r_px_col, r_px_row;
    logic signed [met_pkg::COORD_W-1:0] r_cre, r_cim, r_re, r_im, r_nre, r_nim;
    logic signed [met_pkg::PROD_W-1:0]  r_p0, r_p1, r_p2;

    logic [met_pkg::SIZE_W-1:0]         size_clamped;
    logic [met_pkg::PIX_W-1:0]          half_size;
    logic signed [met_pkg::SIZE_W-1:0]  rel_x, rel_y;
    logic signed [met_pkg::COORD_W-1:0] a0, b0, a1, b1, a2, b2;
    logic signed [met_pkg::PROD_W-1:0]  m0, m1, m2;
    logic signed [met_pkg::PROD_W-1:0]  sq_diff;
    logic [met_pkg::PROD_W-1:0]         mag_sum;
    logic [met_pkg::PROD_W-1:0]         mag;

    // Pixel to relative coordinate, image size clamped to its maximum
    always_comb begin
        size_clamped = (i_image_size > met_pkg::SIZE_W'(met_pkg::MAX_IMAGE_SIZE))
                     ? met_pkg::SIZE_W'(met_pkg::MAX_IMAGE_SIZE) : i_image_size;
        half_size    = size_clamped[met_pkg::SIZE_W-1:1];
        rel_x        = signed'({1'b0, r_px_col} - {1'b0, half_size});
        rel_y        = signed'({1'b0, r_px_row} - {1'b0, half_size});
    end

    // Operand selection for the three shared multipliers
    always_comb begin
        a0 = r_re;
        b0 = r_re;
        a1 = r_im;
        b1 = r_im;
        a2 = r_re;
        b2 = r_im;
        if (i_cmd.map_mul) begin
            a0 = met_pkg::COORD_W'(rel_x);
            b0 = signed'({1'b0, i_step_size});
            a1 = met_pkg::COORD_W'(rel_y);
            b1 = signed'({1'b0, i_step_size});
            a2 = '0;
            b2 = '0;
        end else if (i_cmd.mag_mul) begin
            a0 = r_nre;
            b0 = r_nre;
            a1 = r_nim;
            b1 = r_nim;
            a2 = '0;
            b2 = '0;
        end
    end

    // Signed 32x32 products, sign-extended to the full product width
    assign m0 = met_pkg::PROD_W'(a0) * met_pkg::PROD_W'(b0);
    assign m1 = met_pkg::PROD_W'(a1) * met_pkg::PROD_W'(b1);
    assign m2 = met_pkg::PROD_W'(a2) * met_pkg::PROD_W'(b2);

    // Escape test on the registered squares
    always_comb begin
        sq_diff  = r_p0 - r_p1;
        mag_sum  = unsigned'(r_p0) + unsigned'(r_p1);
        mag      = mag_sum >> met_pkg::FRAC_BITS;
        o_status.escaped = mag > met_pkg::PROD_W'(i_radius_sq);
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) begin
            r_px_col <= i_pixel_column;
            r_px_row <= i_pixel_row;
        end
        if (i_cmd.map_mul || i_cmd.sq_mul || i_cmd.mag_mul) begin
            r_p0 <= m0;
            r_p1 <= m1;
            r_p2 <= m2;
        end
        if (i_cmd.c_load) begin
            r_cre <= met_pkg::sat32(r_p0 + met_pkg::PROD_W'(i_offset_x));
            r_cim <= met_pkg::sat32(r_p1 + met_pkg::PROD_W'(i_offset_y));
            r_re  <= met_pkg::sat32(r_p0 + met_pkg::PROD_W'(i_offset_x));
            r_im  <= met_pkg::sat32(r_p1 + met_pkg::PROD_W'(i_offset_y));
        end
        if (i_cmd.new_calc) begin
            r_nre <= met_pkg::sat32(sq_diff >>> met_pkg::FRAC_BITS);
            r_nim <= met_pkg::sat32(r_p2 >>> (met_pkg::FRAC_BITS - 1));
        end
        if (i_cmd.z_upd) begin
            r_re <= met_pkg::sat32(met_pkg::PROD_W'(r_nre) + met_pkg::PROD_W'(r_cre));
            r_im <= met_pkg::sat32(met_pkg::PROD_W'(r_nim) + met_pkg::PROD_W'(r_cim));
        end
    end

endmodule

[hw/rtl/met_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the escape-time unit: sequencing, round counter, output register.
// Depends on met_pkg; commands met_dp through t_dp_cmd.
module met_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [met_pkg::LIMIT_W-1:0]   o_escape_count,
    input  logic [met_pkg::LIMIT_W-1:0]   i_iter_limit,
    input  met_pkg::t_dp_status           i_status,
    output met_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MAP  = 8'b0000_0010,
        S_CSET = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_NEW  = 8'b0001_0000,
        S_MAG  = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [met_pkg::LIMIT_W-1:0] r_round, n_round;
    logic [met_pkg::LIMIT_W-1:0] r_result, n_result;
    logic                        r_out_valid, n_out_valid;
    logic [met_pkg::LIMIT_W-1:0] r_out_count, n_out_count;

    logic [met_pkg::LIMIT_W:0]   round_inc;
    logic                        last_round;
    logic                        in_beat;
    logic                        out_free;

    assign round_inc  = {1'b0, r_round} + (met_pkg::LIMIT_W+1)'(1);
    assign last_round = round_inc == {1'b0, i_iter_limit};
    assign in_beat    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    // Next state and counters
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: n_state = S_CSET;
            S_CSET: begin
                n_round = '0;
                if (i_iter_limit == '0) begin
                    n_result = i_iter_limit;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ:  n_state = S_NEW;
            S_NEW: n_state = S_MAG;
            S_MAG: n_state = S_CHK;
            S_CHK: begin
                if (i_status.escaped) begin
                    n_result = r_round;
                    n_state  = S_FIN;
                end else if (last_round) begin
                    n_result = i_iter_limit;
                    n_state  = S_FIN;
                end else begin
                    n_round = round_inc[met_pkg::LIMIT_W-1:0];
                    n_state = S_SQ;
                end
            end
            S_FIN: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_px  = in_beat;
        o_cmd.map_mul  = r_state == S_MAP;
        o_cmd.c_load   = r_state == S_CSET;
        o_cmd.sq_mul   = r_state == S_SQ;
        o_cmd.new_calc = r_state == S_NEW;
        o_cmd.mag_mul  = r_state == S_MAG;
        o_cmd.z_upd    = (r_state == S_CHK) && !i_status.escaped;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Counter and result registers
    always_ff @(posedge i_clk) begin
        r_round     <= n_round;
        r_result    <= n_result;
        r_out_count <= n_out_count;
    end

    assign o_in_ready     = r_state == S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;

endmodule

[hw/rtl/mandelbrot_escape_time_unit.sv]
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time unit: configuration registers,
// controller and datapath. Depends on met_pkg, met_ctrl and met_dp.
//
// One pixel (column, row) in, one escape count out. The unit works on one pixel
// at a time: it accepts a pixel in S_IDLE, maps it to the plane in S_MAP and
// S_CSET, and runs each squaring round as S_SQ, S_NEW, S_MAG and S_CHK (square,
// form z', square again, compare and add c), all on one set of three shared
// 32x32 multipliers; S_FIN then moves the count to the output register. With a
// zero limit the squaring rounds are skipped. A finished count waits in the
// output register, so the next pixel may be taken while it is unread; a
// count that finds the previous one still unread holds the unit until it is read.
// No clearing pass after reset. Configuration must be written only while idle;
// the unit itself does not enforce this.
module mandelbrot_escape_time_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [met_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_column,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_row,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [met_pkg::LIMIT_W-1:0]       o_escape_count
);

    logic [met_pkg::LIMIT_W-1:0]        r_iter_limit;
    logic [met_pkg::RADIUS_W-1:0]       r_radius_sq;
    logic [met_pkg::STEP_W-1:0]         r_step_size;
    logic signed [met_pkg::COORD_W-1:0] r_offset_x;
    logic signed [met_pkg::COORD_W-1:0] r_offset_y;
    logic [met_pkg::SIZE_W-1:0]         r_image_size;

    met_pkg::t_dp_cmd    cmd;
    met_pkg::t_dp_status status;

    // Configuration register file; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit <= met_pkg::RST_ITER_LIMIT;
            r_radius_sq  <= met_pkg::RST_RADIUS_SQ;
            r_step_size  <= met_pkg::RST_STEP_SIZE;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_image_size <= met_pkg::RST_IMAGE_SIZE;
        end else if (i_cfg_wr_en) begin
            unique case (met_pkg::t_reg_idx'(i_cfg_index))
                met_pkg::REG_ITER_LIMIT: r_iter_limit <= i_cfg_wdata[met_pkg::LIMIT_W-1:0];
                met_pkg::REG_RADIUS_SQ:  r_radius_sq  <= i_cfg_wdata[met_pkg::RADIUS_W-1:0];
                met_pkg::REG_STEP_SIZE:  r_step_size  <= i_cfg_wdata[met_pkg::STEP_W-1:0];
                met_pkg::REG_OFFSET_X:   r_offset_x   <= signed'(i_cfg_wdata);
                met_pkg::REG_OFFSET_Y:   r_offset_y   <= signed'(i_cfg_wdata);
                met_pkg::REG_IMAGE_SIZE: r_image_size <= i_cfg_wdata[met_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    met_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_escape_count (o_escape_count),
        .i_iter_limit   (r_iter_limit),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // Arithmetic
    met_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_radius_sq    (r_radius_sq),
        .i_step_size    (r_step_size),
        .i_offset_x     (r_offset_x),
        .i_offset_y     (r_offset_y),
        .i_image_size   (r_image_size),
        .o_status       (status)
    );

endmodule

[hw/rtl/met_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the escape-time unit, bound to the top level.
// Depends on met_pkg for port widths.
module met_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [met_pkg::LIMIT_W-1:0]   o_escape_count
);

    // After reset: idle, ready, nothing to deliver
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("unit not idle after reset");

    // One pixel at a time: a taken beat closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second pixel taken while one is in work");

    // A new result only appears at the end of a pixel's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a pixel in work");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_escape_count))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_unit met_chk u_met_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_escape_count (o_escape_count)
);
